/* hw/rtl/ssd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants, types and the glyph lookup for the seven-segment
// decimal serializer.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // Default number of decimal digits shown
    localparam int DIGIT_COUNT_DEF = 4;

    // Bits per seven-segment byte
    localparam int SEG_BITS = 8;

    // Divide by ten: q = (m * DIV10_MAGIC) >> DIV10_SHIFT, exact for 32-bit m
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // Segment masks: a=0, f=1, g=2, e=3, d=4, c=5, b=6, dp=7
    localparam logic [7:0] SEG_A  = 8'h01;
    localparam logic [7:0] SEG_F  = 8'h02;
    localparam logic [7:0] SEG_G  = 8'h04;
    localparam logic [7:0] SEG_E  = 8'h08;
    localparam logic [7:0] SEG_D  = 8'h10;
    localparam logic [7:0] SEG_C  = 8'h20;
    localparam logic [7:0] SEG_B  = 8'h40;
    localparam logic [7:0] SEG_DP = 8'h80;

    // Bit position of the decimal point (always dark)
    localparam logic [2:0] DP_BIT_POS = 3'd7;

    typedef logic [SEG_BITS-1:0] glyph_t;
    typedef logic [3:0]          bcd_t;

    // Decimal digit to segment pattern; non-decimal codes stay dark
    function automatic glyph_t ssd_glyph(input bcd_t digit);
        glyph_t g;
        case (digit)
            4'd0:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1:    g = SEG_B | SEG_C;
            4'd2:    g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4:    g = SEG_F | SEG_G | SEG_B | SEG_C;
            4'd5:    g = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
            4'd6:    g = SEG_A | SEG_F | SEG_G | SEG_E | SEG_C | SEG_D;
            4'd7:    g = SEG_A | SEG_B | SEG_C;
            4'd8:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            default: g = '0;
        endcase
        return g & ~SEG_DP;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ssd_digit_conv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_digit_conv
// Takes the magnitude of a signed value and peels off one decimal digit per
// cycle with a reciprocal multiply; collects the segment bytes of all digits.
// ----------------------------------------------------------------------------
module ssd_digit_conv import ssd_pkg::*; #(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [31:0]            in_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [DIGIT_COUNT*SEG_BITS-1:0]    out_bytes
);

    localparam int CNT_W = $clog2(DIGIT_COUNT + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      mag_reg;
    glyph_t           glyph_reg [DIGIT_COUNT];

    logic        accept;
    logic        hand_off;
    logic [31:0] in_raw;
    logic [31:0] mag_next;
    logic [63:0] prod;
    logic [28:0] quot;
    logic [31:0] quot_x10;
    bcd_t        rem;

    assign accept   = in_valid && in_ready;
    assign hand_off = out_valid && out_ready;
    assign in_ready = !busy_reg && (!done_reg || out_ready);
    assign out_valid = done_reg;

    // Magnitude, most negative value included, without overflow
    assign in_raw   = 32'(in_value);
    assign mag_next = in_raw[31] ? (32'd0 - in_raw) : in_raw;

    // One digit step: divide by ten, remainder is the digit
    assign prod     = 64'(mag_reg) * 64'(DIV10_MAGIC);
    assign quot     = prod[63:DIV10_SHIFT];
    assign quot_x10 = 32'({quot, 3'b000}) + 32'({quot, 1'b0});
    assign rem      = 4'(mag_reg - quot_x10);

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (hand_off) begin
                done_reg <= 1'b0;
            end
            if (accept) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIGIT_COUNT - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude register and glyph collection (digit 0 ends at [0])
    always_ff @(posedge aclk) begin
        if (accept) begin
            mag_reg <= mag_next;
        end else if (busy_reg) begin
            mag_reg <= 32'(quot);
            for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
                glyph_reg[i] <= glyph_reg[i+1];
            end
            glyph_reg[DIGIT_COUNT-1] <= ssd_glyph(rem);
        end
    end

    // Digit 0 in the top byte, shifted out first
    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            out_bytes[(DIGIT_COUNT-i)*SEG_BITS-1 -: SEG_BITS] = glyph_reg[i];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/ssd_shifter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssd_shifter
// Loads the segment bytes of one value and presents them one bit per
// transfer, MSB of each byte first, marking the final bit for the latch.
// ----------------------------------------------------------------------------
module ssd_shifter import ssd_pkg::*; #(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [DIGIT_COUNT*SEG_BITS-1:0] in_bytes,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_seg_bit,
    output logic [1:0]                         m_digit_pos,
    output logic [2:0]                         m_bit_pos,
    output logic                               m_latch_after
);

    localparam int TOTAL = DIGIT_COUNT * SEG_BITS;
    localparam int DIG_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    logic             active_reg;
    logic [TOTAL-1:0] sr_reg;
    logic [DIG_W-1:0] dig_reg;
    logic [2:0]       bit_reg;

    logic       last;
    logic       advance;
    logic [2:0] dig_ext;

    assign last     = (dig_reg == DIG_W'(DIGIT_COUNT - 1)) && (bit_reg == 3'd0);
    assign advance  = m_valid && m_ready;
    assign in_ready = !active_reg || (m_ready && last);

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (in_ready) begin
            active_reg <= in_valid;
        end
    end

    // Shift register and position counters
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            sr_reg  <= in_bytes;
            dig_reg <= '0;
            bit_reg <= 3'd7;
        end else if (advance) begin
            sr_reg  <= {sr_reg[TOTAL-2:0], 1'b0};
            bit_reg <= bit_reg - 3'd1;
            if (bit_reg == 3'd0) begin
                dig_reg <= dig_reg + DIG_W'(1);
            end
        end
    end

    // Result fields straight from registers
    assign dig_ext       = 3'(dig_reg);
    assign m_valid       = active_reg;
    assign m_seg_bit     = sr_reg[TOTAL-1];
    assign m_digit_pos   = dig_ext[1:0];
    assign m_bit_pos     = bit_reg;
    assign m_latch_after = last;

endmodule
`default_nettype wire

/* hw/rtl/seven_segment_decimal_serializer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_decimal_serializer_top
// The serial output moves one segment bit per transfer and sets the value rate;
// digit conversion (one digit per cycle) of the next value overlaps the
// current shift-out.
// Reset clears the busy and valid flags and the digit counter only; no data is kept across values.
// ----------------------------------------------------------------------------
module seven_segment_decimal_serializer_top import ssd_pkg::*; #(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_seg_bit,
    output logic [1:0]              m_digit_pos,
    output logic [2:0]              m_bit_pos,
    output logic                    m_latch_after
);

    logic                            conv_valid;
    logic                            conv_ready;
    logic [DIGIT_COUNT*SEG_BITS-1:0] conv_bytes;

    // Binary to decimal glyphs
    ssd_digit_conv #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_bytes (conv_bytes)
    );

    // Serial output
    ssd_shifter #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_shift (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (conv_valid),
        .in_ready      (conv_ready),
        .in_bytes      (conv_bytes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_seg_bit     (m_seg_bit),
        .m_digit_pos   (m_digit_pos),
        .m_bit_pos     (m_bit_pos),
        .m_latch_after (m_latch_after)
    );

    // Decimal point never lit
    a_dp_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bit_pos == DP_BIT_POS) |-> !m_seg_bit)
        else $error("decimal point bit set");

    // No gap inside one value's bit stream
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_latch_after) |=> m_valid)
        else $error("serial stream broke before latch bit");

    // Converted glyphs are held until the shifter loads them
    a_conv_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (conv_valid && !conv_ready) |=> (conv_valid && $stable(conv_bytes)))
        else $error("glyph handoff dropped or changed");

    // Latch mark only on bit 0
    a_latch_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_latch_after) |-> (m_bit_pos == 3'd0))
        else $error("latch mark off the final bit");

endmodule
`default_nettype wire

/* tb/tb_seven_segment_decimal_serializer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_seven_segment_decimal_serializer_top
// Drives signed values into the serializer and checks every serial segment
// bit against an internal predictor (magnitude, four decimal digits LSD
// first, segment byte MSB first, latch mark on the last bit). Both channels
// see random idle and stall bursts, with full drain pauses before the random part and mid-run.
// ----------------------------------------------------------------------------
module tb_seven_segment_decimal_serializer_top;
    import ssd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS         = DIGIT_COUNT_DEF;
    localparam int BITS_PER_VALUE = DIGITS * SEG_BITS;
    localparam int RANDOM_ITEMS   = 140;
    localparam int TAIL_ITEMS     = 20;
    localparam int SETTLE_CYCLES  = 4 * (DIGITS + 1) + 20;
    localparam int IDLE_LIMIT     = 2000;
    localparam int MAX_REPORTS    = 10;

    // One serial segment bit as seen on the result channel
    typedef struct packed {
        logic       seg_bit;
        logic [1:0] digit_pos;
        logic [2:0] bit_pos;
        logic       latch_after;
    } serial_bit_t;

    // One pending value with its idle gap and drain request
    typedef struct {
        logic [31:0] value;
        int          pre_gap;
        bit          drain_first;
    } stim_item_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_seg_bit;
    logic [1:0]         m_digit_pos;
    logic [2:0]         m_bit_pos;
    logic               m_latch_after;

    stim_item_t  pend_q[$];
    serial_bit_t exp_bits[$];

    int values_in   = 0;
    int bits_out    = 0;
    int mismatches  = 0;
    int idle_cycles = 0;
    bit tail_mode   = 1'b0;

    seven_segment_decimal_serializer_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_seg_bit     (m_seg_bit),
        .m_digit_pos   (m_digit_pos),
        .m_bit_pos     (m_bit_pos),
        .m_latch_after (m_latch_after)
    );

    always #10 aclk = ~aclk;

    // Segment pattern of a decimal digit, dp dark
    function automatic logic [7:0] segment_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1: pat = SEG_B | SEG_C;
            4'd2: pat = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4: pat = SEG_B | SEG_C | SEG_F | SEG_G;
            4'd5: pat = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
            4'd6: pat = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd7: pat = SEG_A | SEG_B | SEG_C;
            4'd8: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            default: pat = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
        endcase
        return pat;
    endfunction

    // Expected serial stream of one value: magnitude, LSD first, MSB first
    task automatic queue_serial_bits(input logic [31:0] raw);
        logic [31:0] mag;
        logic [7:0]  pat;
        serial_bit_t sb;
        int          n;
        mag = raw[31] ? (32'd0 - raw) : raw;
        n   = 0;
        for (int dig = 0; dig < DIGITS; dig++) begin
            pat = segment_pattern(4'(mag % 32'd10));
            mag = mag / 32'd10;
            for (int bit_idx = SEG_BITS - 1; bit_idx >= 0; bit_idx--) begin
                n++;
                sb.seg_bit     = pat[bit_idx];
                sb.digit_pos   = 2'(dig);
                sb.bit_pos     = 3'(bit_idx);
                sb.latch_after = (n == BITS_PER_VALUE);
                exp_bits.push_back(sb);
            end
        end
    endtask

    task automatic add_item(input logic [31:0] value, input int gap, input bit drain);
        stim_item_t it;
        it.value       = value;
        it.pre_gap     = gap;
        it.drain_first = drain;
        pend_q.push_back(it);
    endtask

    // Random value drawn from a mix of digit-oriented classes
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 9999);
            2: v = $urandom_range(0, 214747) * 10000 + $urandom_range(0, 6) - 3;
            3: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0001;
                    2: v = 32'h8000_0000;
                    default: v = 32'h0;
                endcase
            end
            4: v = $urandom_range(0, 9) * 1111;
            default: v = $urandom_range(0, 99999999);
        endcase
        if ($urandom_range(0, 1) == 1)
            v = 32'd0 - v;
        return v;
    endfunction

    // Driver: presents pending values, honors gaps and drain requests
    int gap_left = 0;
    stim_item_t head_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            tail_mode <= (pend_q.size() <= TAIL_ITEMS);
            if (!s_valid || s_ready) begin
                if (pend_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pend_q[0].drain_first &&
                             (s_valid || values_in * BITS_PER_VALUE != bits_out)) begin
                    s_valid <= 1'b0;
                end else begin
                    head_item = pend_q.pop_front();
                    s_valid  <= 1'b1;
                    s_value  <= head_item.value;
                    if (pend_q.size() != 0)
                        gap_left = pend_q[0].pre_gap;
                end
            end
        end
    end

    // Result-side backpressure: bursty stalls, quiet toward the end
    int  stall_left  = 0;
    int  storm_timer = 0;
    bit  storm       = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (storm_timer == 0) begin
                storm       = ($urandom_range(0, 2) != 0);
                storm_timer = $urandom_range(20, 300);
            end else begin
                storm_timer--;
            end
            if (tail_mode) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (storm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each value transfer, checks each bit transfer
    serial_bit_t got_bit;
    serial_bit_t want_bit;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                queue_serial_bits(s_value);
                values_in <= values_in + 1;
            end
            if (m_valid && m_ready) begin
                bits_out <= bits_out + 1;
                got_bit.seg_bit     = m_seg_bit;
                got_bit.digit_pos   = m_digit_pos;
                got_bit.bit_pos     = m_bit_pos;
                got_bit.latch_after = m_latch_after;
                if (exp_bits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected bit seg=%0b digit=%0d bit=%0d latch=%0b",
                                 $realtime, got_bit.seg_bit, got_bit.digit_pos,
                                 got_bit.bit_pos, got_bit.latch_after);
                end else begin
                    want_bit = exp_bits.pop_front();
                    if (got_bit.seg_bit !== want_bit.seg_bit ||
                        got_bit.digit_pos !== want_bit.digit_pos ||
                        got_bit.bit_pos !== want_bit.bit_pos ||
                        got_bit.latch_after !== want_bit.latch_after) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("%0t: bit %0d mismatch: expected seg=%0b digit=%0d ",
                                   $realtime, bits_out, want_bit.seg_bit,
                                   want_bit.digit_pos);
                            $write("bit=%0d latch=%0b, got seg=%0b digit=%0d ",
                                   want_bit.bit_pos, want_bit.latch_after,
                                   got_bit.seg_bit, got_bit.digit_pos);
                            $display("bit=%0d latch=%0b",
                                     got_bit.bit_pos, got_bit.latch_after);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    int leftover;
    int rate;

    initial begin
        // Directed: zero, digit wrap points, all glyphs, sign and extremes
        add_item(32'd0, 0, 1'b0);
        add_item(32'd1, 0, 1'b0);
        add_item(-32'sd1, 0, 1'b0);
        add_item(32'd9, 3, 1'b0);
        add_item(32'd10, 0, 1'b0);
        add_item(32'd9999, 0, 1'b0);
        add_item(32'd10000, 1, 1'b0);
        add_item(-32'sd9999, 0, 1'b0);
        add_item(-32'sd10000, 0, 1'b0);
        add_item(32'd1234, 14, 1'b0);
        add_item(32'd5678, 0, 1'b0);
        add_item(32'd9012, 0, 1'b0);
        add_item(32'd8888, 0, 1'b0);
        add_item(32'd12345678, 2, 1'b0);
        add_item(32'd99999, 0, 1'b0);
        add_item(32'h7FFF_FFFF, 0, 1'b0);
        add_item(32'h8000_0001, 0, 1'b0);
        // most negative value: magnitude 2^31 without overflow
        add_item(32'h8000_0000, 0, 1'b0);
        add_item(32'h5555_5555, 5, 1'b0);
        add_item(32'hAAAA_AAAA, 0, 1'b0);

        // Random part; gap density changes every 20 items, quiet tail
        rate = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 20 == 0) begin
                case ($urandom_range(0, 2))
                    0: rate = 0;
                    1: rate = 15;
                    default: rate = 50;
                endcase
            end
            if (i >= RANDOM_ITEMS - TAIL_ITEMS)
                rate = 0;
            add_item(random_value(),
                     ($urandom_range(0, 99) < rate) ? $urandom_range(1, 14) : 0,
                     (i == 0 || i == RANDOM_ITEMS / 2));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(posedge aclk);
        while (pend_q.size() != 0 || s_valid || values_in * BITS_PER_VALUE != bits_out);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);

        leftover = exp_bits.size();
        if (leftover != 0)
            $display("%0d expected bits never arrived", leftover);
        if (mismatches == 0 && leftover == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
